// File: src/sitk_pkg.sv
// Package for the static interval top-k block: item types, list entry type and op codes.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sitk_pkg;

    // Default depth of the sorted top list
    localparam int TopCountDefault = 32;
    // Devices with an index at or above this count are ignored
    localparam int DeviceCount = 128;

    localparam int TS_W = 62;
    localparam int DEV_W = 7;
    localparam int VAL_W = 32;

    // Op codes of an input item
    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_DEVICE_END = 2'd1;
    localparam logic [1:0] OP_READOUT    = 2'd2;

    // Metric selector codes
    localparam logic [1:0] METRIC_ETVOC = 2'd0;
    localparam logic [1:0] METRIC_ECO2  = 2'd1;
    localparam logic [1:0] METRIC_NOISE = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic [DEV_W-1:0]        device_id;
        logic [TS_W-1:0]         timestamp_us;
        logic                    etvoc_valid;
        logic signed [VAL_W-1:0] etvoc_value;
        logic                    eco2_valid;
        logic signed [VAL_W-1:0] eco2_value;
        logic                    noise_valid;
        logic signed [VAL_W-1:0] noise_value;
    } sample_t;

    typedef struct packed {
        logic                    entry_valid;
        logic [DEV_W-1:0]        out_device;
        logic signed [VAL_W-1:0] out_value;
        logic [TS_W-1:0]         out_duration_us;
        logic                    last;
    } result_t;

    // One interval, either held in a cell or travelling down the chain
    typedef struct packed {
        logic                    valid;
        logic [DEV_W-1:0]        dev;
        logic signed [VAL_W-1:0] value;
        logic [TS_W-1:0]         dur;
    } entry_t;

    // Control shared by all cells of the chain
    typedef struct packed {
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/sitk_run_tracker.sv
// Run tracker: follows the open run of the selected metric and emits a closed interval.
// Depends on sitk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitk_run_tracker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire sitk_pkg::sample_t item,
    input  wire logic [1:0]       metric_select,
    output sitk_pkg::entry_t      tok
);
    import sitk_pkg::*;

    logic                    run_open_reg, run_open_next;
    logic signed [VAL_W-1:0] run_value_reg, run_value_next;
    logic [DEV_W-1:0]        run_device_reg, run_device_next;
    logic [TS_W-1:0]         run_start_reg, run_start_next;
    logic [TS_W-1:0]         run_end_reg, run_end_next;
    entry_t                  tok_reg, tok_next;

    logic                    sel_valid;
    logic signed [VAL_W-1:0] sel_value;
    logic                    dev_in_range;
    logic                    extend;
    logic                    close_run;
    logic [TS_W-1:0]         dur;

    // Pick the tracked metric
    always_comb
    begin
        case (metric_select)
            METRIC_ETVOC:
            begin
                sel_valid = item.etvoc_valid;
                sel_value = item.etvoc_value;
            end
            METRIC_ECO2:
            begin
                sel_valid = item.eco2_valid;
                sel_value = item.eco2_value;
            end
            METRIC_NOISE:
            begin
                sel_valid = item.noise_valid;
                sel_value = item.noise_value;
            end
            default:
            begin
                sel_valid = 1'b0;
                sel_value = '0;
            end
        endcase
    end

    assign dev_in_range = {1'b0, item.device_id} < (DEV_W+1)'(DeviceCount);
    // The run carries on only for the same device with the same valid value
    assign extend = run_open_reg && (run_device_reg == item.device_id) && sel_valid
                    && (sel_value == run_value_reg);
    // A backwards step in time gives a zero length interval
    assign dur = (run_end_reg >= run_start_reg) ? (run_end_reg - run_start_reg) : '0;

    // Next run state and the closing interval
    always_comb
    begin
        run_open_next   = run_open_reg;
        run_value_next  = run_value_reg;
        run_device_next = run_device_reg;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_reg;
        close_run       = 1'b0;
        if (accept && item.op == OP_SAMPLE && dev_in_range)
        begin
            if (extend)
            begin
                run_end_next = item.timestamp_us;
            end
            else
            begin
                close_run     = run_open_reg;
                run_open_next = sel_valid;
                if (sel_valid)
                begin
                    run_value_next  = sel_value;
                    run_device_next = item.device_id;
                    run_start_next  = item.timestamp_us;
                    run_end_next    = item.timestamp_us;
                end
            end
        end
        else if (accept && item.op == OP_DEVICE_END)
        begin
            close_run     = run_open_reg;
            run_open_next = 1'b0;
        end
        tok_next.valid = close_run;
        tok_next.dev   = run_device_reg;
        tok_next.value = run_value_reg;
        tok_next.dur   = dur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            run_value_reg  <= '0;
            run_device_reg <= '0;
            run_start_reg  <= '0;
            run_end_reg    <= '0;
            tok_reg        <= '0;
        end
        else
        begin
            run_open_reg   <= run_open_next;
            run_value_reg  <= run_value_next;
            run_device_reg <= run_device_next;
            run_start_reg  <= run_start_next;
            run_end_reg    <= run_end_next;
            tok_reg        <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

`default_nettype wire

// File: src/sitk_cell.sv
// One cell of the sorted list: holds one interval and passes the shorter one on.
// Depends on sitk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitk_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sitk_pkg::cell_ctrl_t ctrl,
    input  wire sitk_pkg::entry_t    tok_in,
    input  wire logic                bump_in,
    input  wire sitk_pkg::entry_t    right_held,
    output sitk_pkg::entry_t         tok_out,
    output logic                     bump_out,
    output sitk_pkg::entry_t         held
);
    import sitk_pkg::*;

    entry_t held_reg, held_next;
    entry_t tok_reg, tok_next;
    logic   bump_reg, bump_next;
    logic   take_in;

    // A strictly longer interval displaces the held one; ties keep arrival order.
    // An interval pushed down from the cell above arrived earlier than everything
    // below it, so it always takes this cell.
    assign take_in = tok_in.valid
                     && (bump_in || !held_reg.valid || (tok_in.dur > held_reg.dur));

    always_comb
    begin
        held_next       = held_reg;
        tok_next        = tok_in;
        tok_next.valid  = 1'b0;
        bump_next       = 1'b0;
        if (ctrl.shift)
        begin
            // Readout: the list moves one place towards the output
            held_next = right_held;
        end
        else if (take_in)
        begin
            held_next = tok_in;
            tok_next  = held_reg;
            bump_next = 1'b1;
        end
        else if (tok_in.valid)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            tok_reg  <= '0;
            bump_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            tok_reg  <= tok_next;
            bump_reg <= bump_next;
        end
    end

    assign tok_out  = tok_reg;
    assign bump_out = bump_reg;
    assign held     = held_reg;

endmodule

`default_nettype wire

// File: src/static_interval_top_k_top.sv
// Top level of the static interval top-k block: run tracker, chain of list cells, readout.
// Depends on sitk_pkg, sitk_run_tracker and sitk_cell.
//
// Usage:
//   Sample items enter on sample/sample_valid/sample_ready. Sample records and
//   end-of-device items are taken one per cycle while no readout is under way; a
//   closed run enters the head of a chain of TOP_COUNT cells and moves down one
//   cell per cycle until it finds its place in the list, longest first.
//   A readout item blocks the input while the chain drains, then the list is
//   shifted out one slot per cycle on result/result_valid/result_ready:
//   TOP_COUNT items, the last one flagged. After the readout the list is left empty.
//   The result register lets the input open again while the final item waits.
//   A stalled receiver holds the readout; the shifting just pauses.
//   metric_select is written through cfg_wen/cfg_wdata; the user must do this only
//   while the block is idle, as the block itself does not enforce it.
//   Reset empties the list, closes the run and selects the first metric.
`timescale 1ns / 1ps
`default_nettype none

module static_interval_top_k_top #(
    parameter int TOP_COUNT = sitk_pkg::TopCountDefault
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire sitk_pkg::sample_t sample,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output sitk_pkg::result_t      result,
    input  wire logic              cfg_wen,
    input  wire logic [1:0]        cfg_wdata
);
    import sitk_pkg::*;

    localparam int CNT_W = $clog2(TOP_COUNT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SHIFT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             res_valid_reg;
    result_t          res_reg;
    logic [1:0]       metric_select_reg;

    logic             accept;
    logic             chain_busy;
    logic             shift;
    logic             shift_last;
    cell_ctrl_t       ctrl;
    entry_t           tok_chain [TOP_COUNT+1];
    logic             bump_chain [TOP_COUNT+1];
    entry_t           held_chain [TOP_COUNT+1];

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_select_reg <= METRIC_ETVOC;
        end
        else if (cfg_wen)
        begin
            metric_select_reg <= cfg_wdata;
        end
    end

    sitk_run_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .item          (sample),
        .metric_select (metric_select_reg),
        .tok           (tok_chain[0])
    );

    // Chain of list cells; the slot beyond the last one reads as empty.
    // A fresh interval from the tracker is never a pushed-down one.
    assign ctrl.shift               = shift;
    assign held_chain[TOP_COUNT]    = '0;
    assign bump_chain[0]            = 1'b0;

    for (genvar k = 0; k < TOP_COUNT; k++)
    begin : g_cell
        sitk_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .tok_in     (tok_chain[k]),
            .bump_in    (bump_chain[k]),
            .right_held (held_chain[k+1]),
            .tok_out    (tok_chain[k+1]),
            .bump_out   (bump_chain[k+1]),
            .held       (held_chain[k])
        );
    end

    // Any interval still moving down the chain
    always_comb
    begin
        chain_busy = 1'b0;
        for (int k = 0; k <= TOP_COUNT; k++)
        begin
            chain_busy = chain_busy | tok_chain[k].valid;
        end
    end

    assign shift      = (state_reg == ST_SHIFT) && (!res_valid_reg || result_ready);
    assign shift_last = (cnt_reg == CNT_W'(TOP_COUNT - 1));

    // Readout sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // The result register fills on a shift and empties when taken
            if (shift)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && sample.op == OP_READOUT)
                    begin
                        state_reg <= ST_DRAIN;
                        cnt_reg   <= '0;
                    end
                end
                ST_DRAIN:
                begin
                    if (!chain_busy)
                    begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    if (shift)
                    begin
                        res_reg.entry_valid   <= held_chain[0].valid;
                        res_reg.out_device    <= held_chain[0].valid ? held_chain[0].dev : '0;
                        res_reg.out_value     <= held_chain[0].valid ? held_chain[0].value : '0;
                        res_reg.out_duration_us <= held_chain[0].valid ? held_chain[0].dur : '0;
                        res_reg.last          <= shift_last;
                        cnt_reg               <= cnt_reg + 1'b1;
                        if (shift_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef ASSERT_OFF
    // The list is never shifted out while an interval is still being placed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> !chain_busy)
        else $error("readout shift with intervals in flight");

    // A drain always leads into the shift phase, never straight back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg != ST_IDLE))
        else $error("drain left without readout");

    // The final shift raises the last flag and frees the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (shift && shift_last) |=> (result_valid && result.last && state_reg == ST_IDLE))
        else $error("final readout item not flagged");

    // No input item is taken while a readout is under way
    assert property (@(posedge clk) disable iff (!rst_n)
        (shift && !shift_last) |=> !sample_ready)
        else $error("input opened during readout");
`endif

endmodule

`default_nettype wire

// File: tb/static_interval_top_k_top_tb.sv
// Self-checking testbench for static_interval_top_k_top: a directed table, then random
// device groups across metric settings, checked against a local interval ranking model.
// Depends on sitk_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module static_interval_top_k_top_tb;
    import sitk_pkg::*;

    localparam int TOP = TopCountDefault;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_DIRECTED = 22;
    localparam int NUM_PHASES = 5;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] METRIC_NONE = 2'd3;
    localparam logic [TS_W-1:0] TS_MAX = '1;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One row of the directed table; typed rows carry their readout expectation.
    typedef struct {
        sample_t item;
        logic    typed;
        entry_t  top0;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_wen = 1'b0;
    logic [1:0] cfg_wdata = METRIC_ETVOC;

    // Ranking model state: the open run, the sorted list and the selected metric.
    logic [1:0]              metric_sel;
    logic                    run_live;
    logic signed [VAL_W-1:0] run_level;
    logic [DEV_W-1:0]        run_dev;
    logic [TS_W-1:0]         run_first;
    logic [TS_W-1:0]         run_last;
    entry_t                  rank [TOP];
    result_t                 slots_due [$];

    stim_row_t  directed [NUM_DIRECTED];
    logic [1:0] phase_metric [NUM_PHASES];
    int         phase_len [NUM_PHASES];
    bit         metric_seen [4];

    int items_sent = 0;
    int readouts_sent = 0;
    int intervals_closed = 0;
    int slots_checked = 0;
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 8;
    int ready_mode = 0;
    int mode_left = 0;
    int tick = 0;

    static_interval_top_k_top #(
        .TOP_COUNT(TOP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Close the open run and place it in the list, longest first, ties in arrival order.
    task automatic close_interval();
        logic [TS_W-1:0] dur;
        entry_t          fresh;
        int              p;
        if (!run_live)
            return;
        dur = (run_last >= run_first) ? run_last - run_first : '0;
        fresh = '{valid: 1'b1, dev: run_dev, value: run_level, dur: dur};
        run_live = 1'b0;
        intervals_closed++;
        p = 0;
        while (p < TOP && rank[p].valid && rank[p].dur >= dur)
            p++;
        if (p >= TOP)
            return;
        for (int i = TOP - 1; i > p; i--)
            rank[i] = rank[i - 1];
        rank[p] = fresh;
    endtask

    // Advance the model by one accepted item; a readout queues its slots when asked to.
    task automatic predict_item(sample_t it, bit keep);
        logic                    ok;
        logic signed [VAL_W-1:0] level;
        result_t                 r;
        case (it.op)
            OP_SAMPLE:
            begin
                case (metric_sel)
                    METRIC_ETVOC:
                    begin
                        ok = it.etvoc_valid;
                        level = it.etvoc_value;
                    end
                    METRIC_ECO2:
                    begin
                        ok = it.eco2_valid;
                        level = it.eco2_value;
                    end
                    METRIC_NOISE:
                    begin
                        ok = it.noise_valid;
                        level = it.noise_value;
                    end
                    default:
                    begin
                        ok = 1'b0;
                        level = '0;
                    end
                endcase
                if (run_live && run_dev != it.device_id)
                    close_interval();
                if (!ok)
                    close_interval();
                else if (run_live && level == run_level)
                    run_last = it.timestamp_us;
                else
                begin
                    close_interval();
                    run_live = 1'b1;
                    run_level = level;
                    run_dev = it.device_id;
                    run_first = it.timestamp_us;
                    run_last = it.timestamp_us;
                end
            end
            OP_DEVICE_END:
                close_interval();
            OP_READOUT:
            begin
                readouts_sent++;
                for (int k = 0; k < TOP; k++)
                begin
                    r = '0;
                    if (rank[k].valid)
                        r = '{entry_valid: 1'b1, out_device: rank[k].dev,
                              out_value: rank[k].value, out_duration_us: rank[k].dur,
                              last: 1'b0};
                    r.last = (k == TOP - 1);
                    if (keep)
                        slots_due.push_back(r);
                    rank[k].valid = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Queue a readout written out by hand: at most one entry at the head, the rest empty.
    task automatic push_typed(entry_t top0);
        result_t r;
        for (int k = 0; k < TOP; k++)
        begin
            r = '0;
            if (k == 0 && top0.valid)
                r = '{entry_valid: 1'b1, out_device: top0.dev, out_value: top0.value,
                      out_duration_us: top0.dur, last: 1'b0};
            r.last = (k == TOP - 1);
            slots_due.push_back(r);
        end
    endtask

    // Offer one item, wait for it to be taken, then idle between bursts.
    task automatic send_item(sample_t it, bit keep);
        sample <= it;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        if (it.op != OP_UNUSED)
            items_sent++;
        predict_item(it, keep);
        burst_left--;
        if (burst_left <= 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Stop sending, wait for every queued slot, then let the chain settle.
    task automatic drain(int settle);
        sample_valid <= 1'b0;
        while (slots_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the metric selector once the block has gone quiet.
    task automatic set_metric(logic [1:0] m);
        drain(TOP + 8);
        cfg_wdata <= m;
        cfg_wen <= 1'b1;
        @(posedge clk);
        cfg_wen <= 1'b0;
        metric_sel = m;
        metric_seen[m] = 1'b1;
    endtask

    function automatic stim_row_t row(logic [1:0] op, logic [DEV_W-1:0] dev,
                                      logic [TS_W-1:0] ts, logic ev,
                                      logic signed [VAL_W-1:0] eval);
        stim_row_t s;
        s.item = '{op: op, device_id: dev, timestamp_us: ts,
                   etvoc_valid: ev, etvoc_value: eval,
                   eco2_valid: ~ev, eco2_value: ~eval,
                   noise_valid: 1'b1, noise_value: eval ^ 32'sh5A5A_A5A5};
        s.typed = 1'b0;
        s.top0 = '0;
        return s;
    endfunction

    // Any item with every field random; only the op is fixed.
    function automatic sample_t random_item(logic [1:0] op);
        sample_t     it;
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        it.op = op;
        it.device_id = DEV_W'($urandom_range(0, 127));
        it.timestamp_us = wide[TS_W-1:0];
        it.etvoc_valid = 1'($urandom_range(0, 1));
        it.etvoc_value = $urandom();
        it.eco2_valid = 1'($urandom_range(0, 1));
        it.eco2_value = $urandom();
        it.noise_valid = 1'($urandom_range(0, 1));
        it.noise_value = $urandom();
        return it;
    endfunction

    // Half the time a reading holds its level, so runs form; otherwise a new level.
    function automatic logic signed [VAL_W-1:0] next_level(logic signed [VAL_W-1:0] prev);
        case ($urandom_range(0, 5))
            0, 1, 2: return prev;
            3: return $urandom();
            default:
                case ($urandom_range(0, 3))
                    0: return -1;
                    1: return 0;
                    2: return VAL_MIN;
                    default: return VAL_MAX;
                endcase
        endcase
    endfunction

    // A device group: records whose times mostly rise, mostly closed by an end item.
    task automatic run_group();
        sample_t         it;
        logic [TS_W-1:0] ts;
        logic [63:0]     wide;
        int              sel;
        wide = {$urandom(), $urandom()};
        sel = $urandom_range(0, 9);
        if (sel == 0)
            ts = wide[TS_W-1:0];
        else if (sel == 1)
            ts = TS_MAX - TS_W'($urandom_range(0, 400));
        else
            ts = TS_W'($urandom_range(0, 5000));
        it = random_item(OP_SAMPLE);
        repeat ($urandom_range(1, 12))
        begin
            it.timestamp_us = ts;
            it.etvoc_valid = ($urandom_range(0, 9) != 0);
            it.etvoc_value = next_level(it.etvoc_value);
            it.eco2_valid = ($urandom_range(0, 9) != 0);
            it.eco2_value = next_level(it.eco2_value);
            it.noise_valid = ($urandom_range(0, 9) != 0);
            it.noise_value = next_level(it.noise_value);
            send_item(it, 1'b1);
            if ($urandom_range(0, 19) == 0)
                ts = ts - TS_W'($urandom_range(1, 50));
            else
                ts = ts + TS_W'($urandom_range(0, 30));
        end
        if ($urandom_range(0, 4) != 0)
            send_item(random_item(OP_DEVICE_END), 1'b1);
    endtask

    // The receiver changes its stall pattern every so often.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (ready_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 1) == 1);
            2: result_ready <= (tick % 4 == 0);
            default: result_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Compare every accepted result with the oldest queued slot.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (slots_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result with nothing queued: %p", result);
            end
            else
            begin
                want = slots_due.pop_front();
                if (want.entry_valid !== result.entry_valid
                    || want.out_device !== result.out_device
                    || want.out_value !== result.out_value
                    || want.out_duration_us !== result.out_duration_us
                    || want.last !== result.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Slot %0d mismatch: expected valid %0b dev %0d value %h dur %0d last %0b",
                                 slots_checked % TOP, want.entry_valid, want.out_device,
                                 want.out_value, want.out_duration_us, want.last);
                        $display("    got valid %0b dev %0d value %h dur %0d last %0b",
                                 result.entry_valid, result.out_device, result.out_value,
                                 result.out_duration_us, result.last);
                    end
                end
                slots_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d slots outstanding",
                     cycles, slots_due.size());
            $display("[static_interval_top_k_top] ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, final drain and verdict.
    initial
    begin
        sample_t it;
        int      target;
        int      roll;

        metric_sel = METRIC_ETVOC;
        run_live = 1'b0;
        run_level = '0;
        run_dev = '0;
        run_first = '0;
        run_last = '0;
        for (int k = 0; k < TOP; k++)
            rank[k] = '0;

        // Directed table, tracked on the reset metric.
        directed[0]  = row(OP_READOUT, 7'd9, 62'd77, 1'b1, 32'sd3);
        directed[0].typed = 1'b1;
        directed[1]  = row(OP_UNUSED, 7'd2, 62'd5, 1'b1, 32'sd1);
        directed[2]  = row(OP_DEVICE_END, 7'd0, 62'd0, 1'b0, 32'sd0);
        directed[3]  = row(OP_SAMPLE, 7'd0, 62'd0, 1'b1, VAL_MIN);
        directed[4]  = row(OP_SAMPLE, 7'd0, TS_MAX, 1'b1, VAL_MIN);
        directed[5]  = row(OP_DEVICE_END, 7'd127, TS_MAX, 1'b1, VAL_MAX);
        directed[6]  = row(OP_READOUT, 7'd0, 62'd0, 1'b0, 32'sd0);
        directed[6].typed = 1'b1;
        directed[6].top0 = '{valid: 1'b1, dev: 7'd0, value: VAL_MIN, dur: TS_MAX};
        // A reading of all ones is an ordinary value when its valid bit is set.
        directed[7]  = row(OP_SAMPLE, 7'd127, 62'd1000, 1'b1, -32'sd1);
        // Time steps backwards, so this run closes with zero length.
        directed[8]  = row(OP_SAMPLE, 7'd127, 62'd500, 1'b1, -32'sd1);
        directed[9]  = row(OP_SAMPLE, 7'd127, 62'd600, 1'b1, VAL_MAX);
        directed[10] = row(OP_SAMPLE, 7'd127, 62'd900, 1'b0, -32'sd1);
        // A record of another device closes the open run first.
        directed[11] = row(OP_SAMPLE, 7'd3, 62'd10, 1'b1, 32'sd5);
        directed[12] = row(OP_SAMPLE, 7'd4, 62'd20, 1'b1, 32'sd5);
        directed[13] = row(OP_SAMPLE, 7'd4, 62'd70, 1'b1, 32'sd5);
        directed[14] = row(OP_DEVICE_END, 7'd4, 62'd70, 1'b0, 32'sd0);
        directed[15] = row(OP_READOUT, 7'd0, 62'd0, 1'b0, 32'sd0);
        // Two intervals of equal length keep arrival order.
        directed[16] = row(OP_SAMPLE, 7'd1, 62'd0, 1'b1, 32'sd1);
        directed[17] = row(OP_SAMPLE, 7'd1, 62'd40, 1'b1, 32'sd1);
        directed[18] = row(OP_SAMPLE, 7'd1, 62'd41, 1'b1, 32'sd2);
        directed[19] = row(OP_SAMPLE, 7'd1, 62'd81, 1'b1, 32'sd2);
        directed[20] = row(OP_DEVICE_END, 7'd1, 62'd81, 1'b0, 32'sd0);
        directed[21] = row(OP_READOUT, 7'd0, 62'd0, 1'b0, 32'sd0);

        phase_metric = '{METRIC_ECO2, METRIC_NOISE, METRIC_NONE, METRIC_ETVOC, METRIC_NOISE};
        phase_len = '{45, 110, 40, 55, 60};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_item(directed[i].item, !directed[i].typed);
            if (directed[i].typed)
                push_typed(directed[i].top0);
        end

        // Random phases, each on the metric set for it and closed by a readout.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_metric(phase_metric[p]);
            target = items_sent + phase_len[p];
            while (items_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    case ($urandom_range(0, 2))
                        0: it = random_item(OP_SAMPLE);
                        1: it = random_item(OP_DEVICE_END);
                        default: it = random_item(OP_UNUSED);
                    endcase
                    send_item(it, 1'b1);
                end
                else if (roll < 11)
                    send_item(random_item(OP_READOUT), 1'b1);
                else
                    run_group();
            end
            send_item(random_item(OP_READOUT), 1'b1);
        end

        drain(2 * TOP + 8);

        $display("Run covered %0d items and %0d readouts; %0d intervals ranked,",
                 items_sent, readouts_sent, intervals_closed);
        $display("%0d slots checked; metrics etvoc %0b, eco2 %0b, noise %0b, unused code %0b.",
                 slots_checked, metric_seen[METRIC_ETVOC], metric_seen[METRIC_ECO2],
                 metric_seen[METRIC_NOISE], metric_seen[METRIC_NONE]);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0 && slots_due.size() == 0)
            $display("[static_interval_top_k_top] OK");
        else
            $display("[static_interval_top_k_top] ERROR");
        $finish;
    end

endmodule
